### hw/rtl/fupd_pkg.sv
// Shared types, constants and character helpers for the file URI decoder.
`timescale 1ns / 1ps
package fupd_pkg;

  localparam int SCHEME_LEN = 7;   // "file://"
  localparam int HOST_LEN   = 9;   // "localhost"
  localparam int AUTH_SAT   = 10;  // authority length saturates here
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [15:0] CAP_RESET = 16'd4096;
  localparam logic [7:0]  CH_SLASH  = 8'h2F;
  localparam logic [7:0]  CH_PCT    = 8'h25;

  // What the back end has to do with one word
  typedef enum logic [1:0] {
    TK_NONE,   // nothing but the end-of-URI report
    TK_LIT,    // literal path byte: capacity check, then emit
    TK_PCT,    // start of escape: capacity check only
    TK_ESC     // decoded escape byte: emit without check
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  value;
    logic        last;
    logic        front_ok;  // front parser ends in the path phase
  } tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       byte_valid;
    logic       done_res;
    logic       ok;
  } out_word_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'h20;
    return r;
  endfunction

  function automatic logic [7:0] scheme_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h66;  // f
      3'd1:    r = 8'h69;  // i
      3'd2:    r = 8'h6C;  // l
      3'd3:    r = 8'h65;  // e
      3'd4:    r = 8'h3A;  // :
      3'd5:    r = 8'h2F;  // /
      3'd6:    r = 8'h2F;  // /
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] host_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h6C;  // l
      4'd1:    r = 8'h6F;  // o
      4'd2:    r = 8'h63;  // c
      4'd3:    r = 8'h61;  // a
      4'd4:    r = 8'h6C;  // l
      4'd5:    r = 8'h68;  // h
      4'd6:    r = 8'h6F;  // o
      4'd7:    r = 8'h73;  // s
      4'd8:    r = 8'h74;  // t
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]})      r = {1'b1, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h57)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

### hw/rtl/fupd_if.sv
// Valid/ready channel interfaces for URI input and decoded output.
`timescale 1ns / 1ps
interface fupd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] uri_byte;
  logic       last_byte;

  modport source (output valid, uri_byte, last_byte, input ready);
  modport sink   (input valid, uri_byte, last_byte, output ready);
endinterface

interface fupd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       byte_valid;
  logic       done_res;
  logic       ok;

  modport source (output valid, path_byte, byte_valid, done_res, ok, input ready);
  modport sink   (input valid, path_byte, byte_valid, done_res, ok, output ready);
endinterface

### hw/rtl/fupd_front.sv
// Front end: prefix, authority and escape parsing, one byte per cycle in which take is high.
`timescale 1ns / 1ps
module fupd_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         take,
  input  logic [7:0]   uri_byte,
  input  logic         last_byte,
  output logic         push,
  output fupd_pkg::tok_t tok
);
  import fupd_pkg::*;

  typedef enum logic [2:0] {
    PH_PREFIX, PH_AUTH, PH_PATH, PH_ESC_HI, PH_ESC_LO, PH_FAILED
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  prefix_pos_r, prefix_pos_nxt;
  logic [3:0]  auth_cnt_r, auth_cnt_nxt;
  logic        auth_mm_r, auth_mm_nxt;
  logic [3:0]  high_nib_r, high_nib_nxt;
  tok_kind_t   kind;
  logic [7:0]  value;
  logic [7:0]  lc;
  logic [4:0]  hx;

  always_comb begin
    lc             = to_lower(uri_byte);
    hx             = hex_decode(uri_byte);
    phase_nxt      = phase_r;
    prefix_pos_nxt = prefix_pos_r;
    auth_cnt_nxt   = auth_cnt_r;
    auth_mm_nxt    = auth_mm_r;
    high_nib_nxt   = high_nib_r;
    kind           = TK_NONE;
    value          = uri_byte;
    case (phase_r)
      PH_PREFIX: begin
        if (lc == scheme_char(prefix_pos_r)) begin
          prefix_pos_nxt = prefix_pos_r + 3'd1;
          if (prefix_pos_r == 3'(SCHEME_LEN - 1)) phase_nxt = PH_AUTH;
        end else begin
          phase_nxt = PH_FAILED;
        end
      end
      PH_AUTH: begin
        if (uri_byte == CH_SLASH) begin
          if (auth_cnt_r == 4'd0 || (auth_cnt_r == 4'(HOST_LEN) && !auth_mm_r)) begin
            kind      = TK_LIT;   // back end may still fail it on capacity
            phase_nxt = PH_PATH;
          end else begin
            phase_nxt = PH_FAILED;
          end
        end else begin
          if (auth_cnt_r >= 4'(HOST_LEN) || lc != host_char(auth_cnt_r))
            auth_mm_nxt = 1'b1;
          if (auth_cnt_r < 4'(AUTH_SAT)) auth_cnt_nxt = auth_cnt_r + 4'd1;
        end
      end
      PH_PATH: begin
        if (uri_byte == CH_PCT) begin
          kind      = TK_PCT;
          phase_nxt = PH_ESC_HI;
        end else begin
          kind = TK_LIT;
        end
      end
      PH_ESC_HI: begin
        if (hx[4]) begin
          high_nib_nxt = hx[3:0];
          phase_nxt    = PH_ESC_LO;
        end else begin
          phase_nxt = PH_FAILED;
        end
      end
      PH_ESC_LO: begin
        // %00 is rejected like a bad digit
        if (!hx[4] || (high_nib_r == 4'd0 && hx[3:0] == 4'd0)) begin
          phase_nxt = PH_FAILED;
        end else begin
          kind      = TK_ESC;
          value     = {high_nib_r, hx[3:0]};
          phase_nxt = PH_PATH;
        end
      end
      default: phase_nxt = PH_FAILED;
    endcase
  end

  assign tok.kind     = kind;
  assign tok.value    = value;
  assign tok.last     = last_byte;
  assign tok.front_ok = (phase_nxt == PH_PATH);
  assign push         = take && (kind != TK_NONE || last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_PREFIX;
      prefix_pos_r <= '0;
      auth_cnt_r   <= '0;
      auth_mm_r    <= 1'b0;
      high_nib_r   <= '0;
    end else if (take) begin
      if (last_byte) begin
        phase_r      <= PH_PREFIX;
        prefix_pos_r <= '0;
        auth_cnt_r   <= '0;
        auth_mm_r    <= 1'b0;
        high_nib_r   <= '0;
      end else begin
        phase_r      <= phase_nxt;
        prefix_pos_r <= prefix_pos_nxt;
        auth_cnt_r   <= auth_cnt_nxt;
        auth_mm_r    <= auth_mm_nxt;
        high_nib_r   <= high_nib_nxt;
      end
    end
  end

endmodule

### hw/rtl/fupd_queue.sv
// Small word queue between the front parser and the back end.
`timescale 1ns / 1ps
module fupd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fupd_pkg::tok_t    push_tok,
  input  logic              pop,
  output fupd_pkg::tok_t    head_tok,
  output fupd_pkg::q_stat_t stat
);
  import fupd_pkg::*;

  tok_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head_tok   = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### hw/rtl/fupd_back.sv
// Back end: capacity check, output count, sticky failure, output register.
`timescale 1ns / 1ps
module fupd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  fupd_pkg::tok_t      head_tok,
  input  fupd_pkg::q_stat_t   q_stat,
  output logic                pop,
  input  logic                out_ready,
  output logic                out_valid,
  output fupd_pkg::out_word_t out_word
);
  import fupd_pkg::*;

  logic [15:0] cap_r;
  logic [15:0] count_r, count_nxt;
  logic        failed_r, fail_nxt;
  logic        emit;
  logic        cap_hit;
  logic        out_valid_r;
  out_word_t   out_word_r, word_nxt;

  assign pop     = !q_stat.empty && (!out_valid_r || out_ready);
  assign cap_hit = ({1'b0, count_r} + 17'd1) >= {1'b0, cap_r};

  always_comb begin
    fail_nxt = failed_r;
    emit     = 1'b0;
    if (!failed_r) begin
      case (head_tok.kind)
        TK_LIT: begin
          if (cap_hit) fail_nxt = 1'b1;
          else         emit     = 1'b1;
        end
        TK_PCT:  if (cap_hit) fail_nxt = 1'b1;
        TK_ESC:  emit = 1'b1;
        default: ;
      endcase
    end
    count_nxt           = count_r + {15'd0, emit};
    word_nxt.path_byte  = emit ? head_tok.value : 8'd0;
    word_nxt.byte_valid = emit;
    word_nxt.done_res   = head_tok.last;
    word_nxt.ok         = head_tok.last && head_tok.front_ok && !fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (pop) begin
        count_r  <= head_tok.last ? '0 : count_nxt;
        failed_r <= head_tok.last ? 1'b0 : fail_nxt;
      end
      if (pop && (emit || head_tok.last)) out_valid_r <= 1'b1;
      else if (out_ready)                 out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (emit || head_tok.last)) out_word_r <= word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### hw/rtl/file_uri_percent_decoder.sv
// Top level of the file URI percent decoder: front parser, queue, back end.
//
//   channel   dir  handshake            word
//   in_ch     in   valid/ready          uri_byte[7:0], last_byte
//   out_ch    out  valid/ready          path_byte[7:0], byte_valid, done_res, ok
//   cfg_*     in   cfg_wr_en (no wait)  cfg_wr_data[15:0] = out_capacity
//
// Throughput is one input word per cycle while the queue has room. At the
// earliest, an input word's result reaches out_ch through the queue and
// then the output register: the front parser is combinational, the queue
// captures the accepted word, and the output register loads the queue head.
// in_ch.ready is low only while the two-entry queue is full, so output stalls
// reach the input after the queue and the output register have filled.
// Reset (rst_n low, synchronous) clears all parse state, empties the queue
// and sets out_capacity to 4096.
`timescale 1ns / 1ps
module file_uri_percent_decoder (
  input  logic        clk,
  input  logic        rst_n,
  fupd_in_if.sink     in_ch,
  fupd_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import fupd_pkg::*;

  logic      take;
  logic      push;
  logic      pop;
  tok_t      push_tok;
  tok_t      head_tok;
  q_stat_t   q_stat;
  out_word_t out_word;
  logic      out_valid;

  // Accept whenever the queue has room; the front parser itself adds no stall.
  assign in_ch.ready = !q_stat.full;
  assign take        = in_ch.valid && in_ch.ready;

  // Front: per-byte parsing of scheme, authority and escapes.
  fupd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .uri_byte  (in_ch.uri_byte),
    .last_byte (in_ch.last_byte),
    .push      (push),
    .tok       (push_tok)
  );

  // Decouples the parser from output backpressure.
  fupd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .stat     (q_stat)
  );

  // Back: capacity accounting, sticky failure and the output register.
  fupd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_tok    (head_tok),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_ready   (out_ch.ready),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.path_byte  = out_word.path_byte;
  assign out_ch.byte_valid = out_word.byte_valid;
  assign out_ch.done_res   = out_word.done_res;
  assign out_ch.ok         = out_word.ok;

  // Every word carries either a byte or the end-of-URI report.
  a_word_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.byte_valid || out_ch.done_res))
    else $error("output word with neither byte nor done");

  // ok only accompanies done.
  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ok) |-> out_ch.done_res)
    else $error("ok set without done");

  // A word that carries no byte shows a zero byte.
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.byte_valid) |-> (out_ch.path_byte == 8'd0))
    else $error("nonzero path_byte without byte_valid");

  // The back end never pops an empty queue and the queue never reports both.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty))
    else $error("queue status inconsistent");

endmodule

### test/file_uri_percent_decoder_tb.sv
// Self-checking testbench for the file URI percent decoder.
`timescale 1ns / 1ps
module file_uri_percent_decoder_tb;
  import fupd_pkg::*;

  // Parser states of the predictor
  typedef enum logic [2:0] {
    ST_SCHEME,
    ST_HOST,
    ST_PATH,
    ST_ESC_HI,
    ST_ESC_LO,
    ST_FAILED
  } parse_st_t;

  // One input word as queued for the driver
  typedef struct packed {
    logic [7:0] b;
    logic       lst;
  } uri_word_t;

  localparam logic [55:0] SCHEME_TXT = "file://";
  localparam logic [71:0] HOST_TXT   = "localhost";
  localparam logic [7:0]  CH_A_UP    = 8'h41;
  localparam logic [7:0]  CH_Z_UP    = 8'h5A;
  localparam logic [7:0]  CH_A_LO    = 8'h61;
  localparam logic [7:0]  CH_Z_LO    = 8'h7A;
  localparam int          PHASES     = 8;
  localparam int          PHASE_WORDS = 175;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  fupd_in_if  in_if();
  fupd_out_if out_if();

  file_uri_percent_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Stimulus and scoreboard state
  uri_word_t  pending_words[$];    // words waiting for the driver
  out_word_t  expected_words[$];   // predicted results, oldest first
  logic [7:0] uri_buf[$];          // URI under construction
  int         words_left = 0;      // queued but not yet accepted
  int         idle_pct   = 0;      // sender idle chance, percent
  int         stall_pct  = 0;      // receiver stall chance, percent
  int         mismatches = 0;

  // Predictor state: shadow of the parser plus the capacity register
  parse_st_t  st;
  int         scheme_n;
  int         host_n;
  bit         host_bad;
  logic [3:0] esc_hi;
  int         emitted;
  int         capacity;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= CH_A_UP && c <= CH_Z_UP) ? c + 8'd32 : c;
  endfunction

  // Hex digit value, -1 when the byte is not a hex digit
  function automatic int hex_nibble(input logic [7:0] c);
    logic [7:0] f;
    f = fold_case(c);
    if (f >= "0" && f <= "9") return int'(f) - int'("0");
    if (f >= "a" && f <= "f") return int'(f) - int'("a") + 10;
    return -1;
  endfunction

  function automatic void clear_parse();
    st       = ST_SCHEME;
    scheme_n = 0;
    host_n   = 0;
    host_bad = 1'b0;
    esc_hi   = 4'd0;
    emitted  = 0;
  endfunction

  // Path level byte: room check first, then literal or escape start
  function automatic bit path_take(input logic [7:0] b, output logic [7:0] val);
    val = 8'd0;
    if (emitted + 1 >= capacity) begin
      st = ST_FAILED;
      return 1'b0;
    end
    if (b == CH_PCT) begin
      st = ST_ESC_HI;
      return 1'b0;
    end
    st = ST_PATH;
    val = b;
    emitted++;
    return 1'b1;
  endfunction

  // Advances the shadow parser by one word; 1 when a result is due
  function automatic bit uri_step(input logic [7:0] b, input logic lst,
                                  output out_word_t w);
    bit         emit;
    logic [7:0] val;
    int         h;
    emit = 1'b0;
    val  = 8'd0;
    w    = '0;
    case (st)
      ST_SCHEME: begin
        if (scheme_n < SCHEME_LEN && fold_case(b) == SCHEME_TXT[8*(6-scheme_n) +: 8]) begin
          scheme_n++;
          if (scheme_n == SCHEME_LEN) st = ST_HOST;
        end else begin
          st = ST_FAILED;
        end
      end
      ST_HOST: begin
        if (b == CH_SLASH) begin
          if (host_n == 0 || (host_n == HOST_LEN && !host_bad)) emit = path_take(b, val);
          else st = ST_FAILED;
        end else begin
          if (host_n >= HOST_LEN || fold_case(b) != HOST_TXT[8*(8-host_n) +: 8])
            host_bad = 1'b1;
          if (host_n < AUTH_SAT) host_n++;
        end
      end
      ST_PATH: emit = path_take(b, val);
      ST_ESC_HI: begin
        h = hex_nibble(b);
        if (h < 0) begin
          st = ST_FAILED;
        end else begin
          esc_hi = h[3:0];
          st = ST_ESC_LO;
        end
      end
      ST_ESC_LO: begin
        h = hex_nibble(b);
        if (h < 0 || (esc_hi == 4'd0 && h == 0)) begin
          st = ST_FAILED;
        end else begin
          val = {esc_hi, h[3:0]};
          emit = 1'b1;
          emitted++;
          st = ST_PATH;
        end
      end
      default: st = ST_FAILED;
    endcase
    if (!emit && !lst) return 1'b0;
    w.path_byte  = emit ? val : 8'd0;
    w.byte_valid = emit;
    w.done_res   = lst;
    w.ok         = lst && st == ST_PATH;
    if (lst) clear_parse();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // URI builders
  // ---------------------------------------------------------------
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) uri_buf.push_back(s[i]);
  endtask

  // Random case on letters only
  function automatic logic [7:0] any_case(input logic [7:0] c);
    if (c >= CH_A_LO && c <= CH_Z_LO && $urandom_range(1) == 1) return c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return any_case(8'("a") + 8'(n) - 8'd10);
  endfunction

  function automatic logic [7:0] non_slash();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_SLASH);
    return c;
  endfunction

  // Moves the URI under construction to the driver queue, last flag on its end
  task automatic flush_uri();
    uri_word_t w;
    while (uri_buf.size() != 0) begin
      w.b   = uri_buf.pop_front();
      w.lst = (uri_buf.size() == 0);
      pending_words.push_back(w);
      words_left++;
    end
  endtask

  // One random URI: mostly well formed with random content, some broken
  task automatic random_uri();
    int         kind;
    int         n;
    int         r;
    int         v;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // plain noise
      n = $urandom_range(1, 10);
      repeat (n) uri_buf.push_back(8'($urandom_range(1, 255)));
      flush_uri();
      return;
    end
    n = (kind < 15) ? $urandom_range(0, 6) : SCHEME_LEN;
    for (int i = 0; i < n; i++) uri_buf.push_back(any_case(SCHEME_TXT[8*(6-i) +: 8]));
    if (kind < 15) begin
      // scheme cut short, or spoiled by one stray byte
      if (n == 0 || $urandom_range(1) == 1) uri_buf.push_back(8'($urandom_range(1, 255)));
      flush_uri();
      return;
    end
    // authority
    r = $urandom_range(9);
    if (r >= 5 && r <= 7) begin
      for (int i = 0; i < HOST_LEN; i++) uri_buf.push_back(any_case(HOST_TXT[8*(8-i) +: 8]));
    end else if (r == 8) begin
      n = $urandom_range(1, 13);
      repeat (n) uri_buf.push_back(non_slash());
    end else if (r == 9) begin
      // near miss of localhost: too short or too long
      n = $urandom_range(1, 10);
      if (n >= HOST_LEN) n++;
      for (int i = 0; i < n; i++)
        uri_buf.push_back(i < HOST_LEN ? any_case(HOST_TXT[8*(8-i) +: 8]) : non_slash());
    end
    if ($urandom_range(99) < 3) begin
      flush_uri();  // ends inside the authority
      return;
    end
    uri_buf.push_back(CH_SLASH);
    // path
    n = $urandom_range(0, 16);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 68) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_PCT);
        uri_buf.push_back(c);
      end else if (r < 90) begin
        v = $urandom_range(1, 255);
        uri_buf.push_back(CH_PCT);
        uri_buf.push_back(hex_char(v[7:4]));
        uri_buf.push_back(hex_char(v[3:0]));
      end else if (r < 94) begin
        uri_buf.push_back(CH_PCT);
        uri_buf.push_back("0");
        uri_buf.push_back("0");
      end else begin
        // non-hex digit in either escape position
        uri_buf.push_back(CH_PCT);
        if ($urandom_range(1) == 1) uri_buf.push_back(hex_char(4'($urandom_range(15))));
        do c = 8'($urandom_range(1, 255)); while (hex_nibble(c) >= 0);
        uri_buf.push_back(c);
      end
    end
    if ($urandom_range(99) < 5) begin
      // ends inside an escape
      uri_buf.push_back(CH_PCT);
      if ($urandom_range(1) == 1) uri_buf.push_back(hex_char(4'($urandom_range(1, 15))));
    end
    flush_uri();
  endtask

  // Waits until every queued word is taken and every result is back,
  // then lets the pipeline run dry
  task automatic drain();
    while (words_left != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------
  // Driver: offers queued words, predicts at each accepted word
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    uri_word_t w;
    out_word_t r;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (uri_step(in_if.uri_byte, in_if.last_byte, r)) expected_words.push_back(r);
        words_left--;
      end
      // a new word may be offered only once the current one is gone
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          w = pending_words.pop_front();
          in_if.valid     <= 1'b1;
          in_if.uri_byte  <= w.b;
          in_if.last_byte <= w.lst;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Monitor: compares each accepted result with the oldest prediction
  // ---------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: path_byte 0x%0h byte_valid %0b done_res %0b ok %0b",
                 out_if.path_byte, out_if.byte_valid, out_if.done_res, out_if.ok);
          mismatches++;
        end else begin
          e = expected_words.pop_front();
          check_field("path_byte", e.path_byte, out_if.path_byte);
          check_field("byte_valid", e.byte_valid, out_if.byte_valid);
          check_field("done_res", e.done_res, out_if.done_res);
          check_field("ok", e.ok, out_if.ok);
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------
  // Sequence: reset, directed URIs, then phases of random URIs, each
  // with its own capacity and, repeating every fourth phase, an idle/stall pattern
  // ---------------------------------------------------------------
  initial begin
    int caps[PHASES];
    int base;
    caps = '{4096, 0, 1, 2, 3, 7, 65535, 20};
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 16'd0;
    in_if.valid     = 1'b0;
    in_if.uri_byte  = 8'd0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    capacity        = int'(CAP_RESET);
    clear_parse();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // mixed-case scheme, empty authority, escape from mixed-case digits,
    // smallest nonzero and largest byte values
    add_text("File:///%fF");
    uri_buf.push_back(8'h01);
    flush_uri();
    add_text("fil");         // ends inside the scheme
    flush_uri();
    add_text("file:///%0");  // ends inside an escape
    flush_uri();

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        // capacity changes only with the block idle
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 16'(caps[p]);
        capacity     = caps[p];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
      end
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 48; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      base = words_left;
      while (words_left - base < PHASE_WORDS) random_uri();
    end

    drain();
    if (mismatches == 0) begin
      $display("file_uri_percent_decoder_tb passed");
    end else begin
      $display("file_uri_percent_decoder_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("file_uri_percent_decoder_tb failed");
    $finish;
  end

endmodule
